[hdl/tsfi_pkg.sv]
`default_nettype none
package tsfi_pkg;

   localparam logic [2:0] TC_F32 = 3'd0;
   localparam logic [2:0] TC_F64 = 3'd1;
   localparam logic [2:0] TC_S8  = 3'd2;
   localparam logic [2:0] TC_U8  = 3'd3;
   localparam logic [2:0] TC_S16 = 3'd4;
   localparam logic [2:0] TC_U16 = 3'd5;
   localparam logic [2:0] TC_S32 = 3'd6;
   localparam logic [2:0] TC_U32 = 3'd7;

   typedef struct packed {
      logic [63:0] raw_bits;
      logic [2:0]  type_code;
   } req_type;

   typedef struct packed {
      logic [31:0]        float_bits;
      logic signed [31:0] int_value;
      logic               int_saturated;
   } rsp_type;

   // Unpacked float: sign, unbiased exponent, 53-bit mantissa (hidden bit at 52)
   typedef struct packed {
      logic               sign;
      logic               is_nan;
      logic               is_inf;
      logic               is_zero;
      logic               is_float;
      logic signed [12:0] exp;
      logic [52:0]        mant;
      logic [21:0]        nan_payload;
      logic               pass32;
      logic [31:0]        pass_bits;
      logic [31:0]        ival;
   } unp_type;

endpackage
`default_nettype wire

[hdl/tsfi_stream_if.sv]
`default_nettype none
interface tsfi_req_if;
   logic              valid;
   logic              ready;
   tsfi_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tsfi_rsp_if;
   logic              valid;
   logic              ready;
   tsfi_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/tsfi_core.sv]
`default_nettype none
module tsfi_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire tsfi_pkg::req_type in_item,
   output logic                   out_valid,
   output tsfi_pkg::rsp_type      out_item
);

   // stage 1: unpack
   tsfi_pkg::unp_type s1_in, s1_ff;
   logic              v1_ff, v2_ff, v3_ff;

   logic [63:0] raw;
   logic [63:0] mag;
   logic        neg;
   logic [5:0]  lz;
   logic        found;

   always_comb begin
      raw = in_item.raw_bits;
      s1_in = '0;
      neg = 1'b0;
      mag = '0;
      case (in_item.type_code)
         tsfi_pkg::TC_F32: begin
            s1_in.is_float  = 1'b1;
            s1_in.pass32    = 1'b1;
            s1_in.pass_bits = raw[31:0];
            s1_in.sign      = raw[31];
            s1_in.is_nan    = (raw[30:23] == 8'hFF) && (raw[22:0] != '0);
            s1_in.is_inf    = (raw[30:23] == 8'hFF) && (raw[22:0] == '0);
            s1_in.is_zero   = (raw[30:0] == '0);
            if (raw[30:23] == 8'd0) begin
               s1_in.exp  = -13'sd126;
               s1_in.mant = {1'b0, raw[22:0], 29'd0};
            end else begin
               s1_in.exp  = $signed({5'd0, raw[30:23]}) - 13'sd127;
               s1_in.mant = {1'b1, raw[22:0], 29'd0};
            end
         end
         tsfi_pkg::TC_F64: begin
            s1_in.is_float    = 1'b1;
            s1_in.sign        = raw[63];
            s1_in.is_nan      = (raw[62:52] == 11'h7FF) && (raw[51:0] != '0);
            s1_in.is_inf      = (raw[62:52] == 11'h7FF) && (raw[51:0] == '0);
            s1_in.is_zero     = (raw[62:0] == '0);
            s1_in.nan_payload = raw[50:29];
            if (raw[62:52] == 11'd0) begin
               s1_in.exp  = -13'sd1022;
               s1_in.mant = {1'b0, raw[51:0]};
            end else begin
               s1_in.exp  = $signed({2'd0, raw[62:52]}) - 13'sd1023;
               s1_in.mant = {1'b1, raw[51:0]};
            end
         end
         default: begin
            case (in_item.type_code)
               tsfi_pkg::TC_S8:  begin neg = raw[7];  mag = neg ? 64'(-$signed(raw[7:0]))
                                                             : {56'd0, raw[7:0]}; end
               tsfi_pkg::TC_U8:  mag = {56'd0, raw[7:0]};
               tsfi_pkg::TC_S16: begin neg = raw[15]; mag = neg ? 64'(-$signed(raw[15:0]))
                                                              : {48'd0, raw[15:0]}; end
               tsfi_pkg::TC_U16: mag = {48'd0, raw[15:0]};
               tsfi_pkg::TC_S32: begin neg = raw[31]; mag = neg ? 64'(-$signed(raw[31:0]))
                                                              : {32'd0, raw[31:0]}; end
               default:          mag = {32'd0, raw[31:0]};
            endcase
            s1_in.sign    = neg;
            s1_in.is_zero = (mag[31:0] == '0);
            s1_in.ival    = neg ? -mag[31:0] : mag[31:0];
            // integer m * 2^0 expressed with point after bit 52: value = mag[31:0] * 2^-52 * 2^52
            s1_in.exp  = 13'sd52;
            s1_in.mant = {21'd0, mag[31:0]};
         end
      endcase
   end

   // stage 2: normalize (leading zero count over 53 bits)
   tsfi_pkg::unp_type s2_ff;
   logic [52:0]        nmant;
   logic signed [12:0] nexp;

   always_comb begin
      lz = '0;
      found = 1'b0;
      for (int i = 52; i >= 0; i--) begin
         if (!found && s1_ff.mant[i]) begin
            found = 1'b1;
            lz = 6'(52 - i);
         end
      end
      nmant = s1_ff.mant << lz;
      nexp  = s1_ff.exp - $signed({7'd0, lz});
   end

   // stage 3: round to binary32 and truncate to int32
   logic [31:0]        f_in;
   logic [31:0]        i_in;
   logic               sat_in;
   logic signed [12:0] e;
   logic [7:0]         shr;
   logic [54:0]        ext;
   logic [54:0]        shifted;
   logic               sticky;
   logic [23:0]        kept;
   logic               g, st;
   logic [24:0]        rnd;
   logic [8:0]         bexp;
   logic [31:0]        imag;
   logic [31:0]        f3_ff, i3_ff;
   logic               sat3_ff;

   always_comb begin
      e = s2_ff.exp;
      f_in = '0;
      ext = '0; shifted = '0; sticky = 1'b0; kept = '0; g = 1'b0; st = 1'b0;
      rnd = '0; bexp = '0; shr = '0;
      imag = '0;
      // float result
      if (s2_ff.pass32) begin
         f_in = s2_ff.pass_bits;
      end else if (s2_ff.is_nan) begin
         f_in = {s2_ff.sign, 9'h1FF, s2_ff.nan_payload};
      end else if (s2_ff.is_inf || e > 13'sd127) begin
         f_in = {s2_ff.sign, 8'hFF, 23'd0};
      end else if (s2_ff.is_zero) begin
         f_in = {s2_ff.sign, 31'd0};
      end else begin
         // normal keeps 24 bits; subnormal shifts right by (-126 - e), capped at 40
         if (e < -13'sd126)
            shr = ((-13'sd126 - e) > 13'sd40) ? 8'd40 : 8'(-13'sd126 - e);
         ext = {s2_ff.mant, 2'b00};
         shifted = ext >> shr;
         sticky = 1'b0;
         for (int k = 0; k < 55; k++)
            if (k < 29 + 32'(shr) && ext[k]) sticky = 1'b1;
         kept = shifted[54:31];
         g    = shifted[30];
         st   = sticky || (shifted[29:0] != '0);
         rnd  = {1'b0, kept} + 25'(g && (st || kept[0]));
         if (e < -13'sd126)
            bexp = {8'd0, rnd[23]};
         else
            bexp = 9'(e + 13'sd127) + 9'(rnd[24]);
         if (bexp >= 9'd255)
            f_in = {s2_ff.sign, 8'hFF, 23'd0};
         else
            f_in = {s2_ff.sign, bexp[7:0], rnd[24] ? rnd[23:1] : rnd[22:0]};
      end
      // integer result
      sat_in = 1'b0;
      i_in = '0;
      if (!s2_ff.is_float) begin
         i_in = s2_ff.ival;
      end else if (s2_ff.is_nan) begin
         sat_in = 1'b1;
      end else if (s2_ff.is_inf || e > 13'sd31 ||
                   (e == 13'sd31 && !(s2_ff.sign && s2_ff.mant[51:21] == '0))) begin
         sat_in = 1'b1;
         i_in = s2_ff.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (!s2_ff.is_zero && e >= 13'sd0) begin
         imag = 32'(s2_ff.mant >> (6'd52 - 6'(e)));
         i_in = s2_ff.sign ? -imag : imag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
      end
   end

   tsfi_pkg::unp_type s2_in;
   always_comb begin
      s2_in = s1_ff;
      s2_in.mant = nmant;
      s2_in.exp  = nexp;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         f3_ff   <= f_in;
         i3_ff   <= i_in;
         sat3_ff <= sat_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = '{float_bits: f3_ff, int_value: $signed(i3_ff), int_saturated: sat3_ff};

endmodule
`default_nettype wire

[hdl/typed_scalar_to_float_and_int.sv]
// Throughput: one item per cycle; three register stages (unpack,
// normalize, round/truncate) advance together and hold on a stall.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none
module typed_scalar_to_float_and_int (
   input wire logic   clock,
   input wire logic   reset,
   tsfi_req_if.sink   req,
   tsfi_rsp_if.source rsp
);

   logic advance;

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   tsfi_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .in_item   (req.payload),
      .out_valid (rsp.valid),
      .out_item  (rsp.payload)
   );

endmodule
`default_nettype wire

[sim/tb_typed_scalar_to_float_and_int.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_typed_scalar_to_float_and_int;

   localparam int STALL_LIMIT = 2000;
   localparam int N_RANDOM = 930;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsfi_req_if req_ch();
   tsfi_rsp_if rsp_ch();

   typed_scalar_to_float_and_int i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #5 clock = ~clock;

   tsfi_pkg::req_type pending_items[$];
   tsfi_pkg::rsp_type expected_rsps[$];
   int send_idle_pct = 37;
   int recv_idle_pct = 70;
   bit hold_send = 1'b0;
   bit all_sent = 1'b0;
   bit req_taken = 1'b0;
   int failures = 0;
   int quiet_cycles = 0;

   // Round-to-nearest-even of an unsigned magnitude to 24 bits; returns binary32 bits.
   function automatic logic [31:0] int_to_binary32(input logic sgn, input logic [63:0] mag);
      int msb;
      logic [63:0] m;
      logic [63:0] rem;
      logic [63:0] half;
      int sh;
      logic [24:0] kept;
      int e;
      msb = -1;
      if (mag == 0) return {sgn, 31'd0};
      for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
      e = msb;
      if (msb <= 23) begin
         kept = 25'(mag << (23 - msb));
      end else begin
         sh = msb - 23;
         m = mag >> sh;
         rem = mag & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         kept = m[24:0];
         if (rem > half || (rem == half && m[0])) kept = kept + 25'd1;
         if (kept[24]) begin
            kept = kept >> 1;
            e = e + 1;
         end
      end
      return {sgn, 8'(e + 127), kept[22:0]};
   endfunction

   // binary64 to binary32 with round-to-nearest-even, subnormals kept.
   function automatic logic [31:0] narrow_double(input logic [63:0] d);
      logic sgn;
      int ex;
      logic [52:0] man;
      int e32;
      int sh;
      logic [76:0] wide;
      logic [24:0] kept;
      logic [76:0] rem;
      logic [76:0] half;
      sgn = d[63];
      ex = int'(d[62:52]);
      if (ex == 2047) begin
         if (d[51:0] != 0)
            return {sgn, 8'hFF, 1'b1, d[50:29]};
         return {sgn, 8'hFF, 23'd0};
      end
      if (ex == 0 && d[51:0] == 0) return {sgn, 31'd0};
      man = (ex == 0) ? {1'b0, d[51:0]} : {1'b1, d[51:0]};
      if (ex == 0) ex = 1;
      // value = man * 2^(ex-1075); target kept as 24-bit mantissa
      e32 = ex - 1023 + 127;
      if (e32 >= 1) sh = 29;
      else sh = 29 + (1 - e32);
      if (sh > 76) sh = 76;
      wide = {24'd0, man};
      kept = 25'(wide >> sh);
      rem = wide & ((77'd1 << sh) - 77'd1);
      half = 77'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 25'd1;
      if (e32 < 1) e32 = 1;
      if (kept[24]) begin
         kept = kept >> 1;
         e32 = e32 + 1;
      end
      if (ex == 1 || d[62:52] == 0 || e32 == 1) begin
         if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
      end
      if (e32 >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(e32), kept[22:0]};
   endfunction

   // Truncation of a binary64 toward zero with saturation.
   function automatic void double_to_int(input logic [63:0] d,
                                         output logic signed [31:0] val, output logic sat);
      int ex;
      logic [52:0] man;
      logic [63:0] mag;
      ex = int'(d[62:52]);
      sat = 1'b0;
      if (ex == 2047 && d[51:0] != 0) begin
         val = 0;
         sat = 1'b1;
         return;
      end
      if (ex < 1023) begin
         val = 0;
         return;
      end
      if (ex >= 1023 + 32) begin
         sat = 1'b1;
         val = d[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
         return;
      end
      man = {1'b1, d[51:0]};
      if (ex - 1023 >= 52) mag = 64'(man) << (ex - 1023 - 52);
      else mag = 64'(man) >> (52 - (ex - 1023));
      if (!d[63] && mag >= 64'h80000000) begin
         sat = 1'b1;
         val = 32'sh7FFFFFFF;
      end else if (d[63] && mag > 64'h80000000) begin
         sat = 1'b1;
         val = 32'sh80000000;
      end else begin
         val = d[63] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
      end
   endfunction

   function automatic logic [63:0] widen_single(input logic [31:0] f);
      int ex;
      int msb;
      logic [22:0] fr;
      ex = int'(f[30:23]);
      fr = f[22:0];
      if (ex == 255) return {f[31], 11'h7FF, fr, 29'd0};
      if (ex == 0) begin
         if (fr == 0) return {f[31], 63'd0};
         msb = 0;
         for (int i = 0; i < 23; i++) if (fr[i]) msb = i;
         return {f[31], 11'(msb - 149 + 1023), 52'(64'(fr) << (52 - msb))};
      end
      return {f[31], 11'(ex - 127 + 1023), fr, 29'd0};
   endfunction

   function automatic tsfi_pkg::rsp_type convert_scalar(input tsfi_pkg::req_type it);
      tsfi_pkg::rsp_type r;
      logic signed [63:0] iv;
      logic [63:0] d;
      r.int_saturated = 1'b0;
      iv = 0;
      case (it.type_code)
         tsfi_pkg::TC_F32: begin
            r.float_bits = it.raw_bits[31:0];
            d = widen_single(it.raw_bits[31:0]);
            double_to_int(d, r.int_value, r.int_saturated);
         end
         tsfi_pkg::TC_F64: begin
            r.float_bits = narrow_double(it.raw_bits);
            double_to_int(it.raw_bits, r.int_value, r.int_saturated);
         end
         tsfi_pkg::TC_S8:  iv = 64'($signed(it.raw_bits[7:0]));
         tsfi_pkg::TC_U8:  iv = {56'd0, it.raw_bits[7:0]};
         tsfi_pkg::TC_S16: iv = 64'($signed(it.raw_bits[15:0]));
         tsfi_pkg::TC_U16: iv = {48'd0, it.raw_bits[15:0]};
         tsfi_pkg::TC_S32: iv = 64'($signed(it.raw_bits[31:0]));
         default: iv = {32'd0, it.raw_bits[31:0]};
      endcase
      if (it.type_code != tsfi_pkg::TC_F32 && it.type_code != tsfi_pkg::TC_F64) begin
         r.float_bits = int_to_binary32(iv[63], iv[63] ? 64'(-iv) : 64'(iv));
         r.int_value = iv[31:0];
      end
      return r;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_items.size() > 0 && !hold_send &&
             $urandom_range(99) >= send_idle_pct) begin
            req_ch.payload <= pending_items.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(convert_scalar(req_ch.payload));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result %h", rsp_ch.payload);
               failures++;
            end else begin
               tsfi_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.float_bits !== rsp_ch.payload.float_bits) begin
                  $error("float_bits exp %h got %h", e.float_bits, rsp_ch.payload.float_bits);
                  failures++;
               end
               if (e.int_value !== rsp_ch.payload.int_value) begin
                  $error("int_value exp %0d got %0d", e.int_value, rsp_ch.payload.int_value);
                  failures++;
               end
               if (e.int_saturated !== rsp_ch.payload.int_saturated) begin
                  $error("int_saturated exp %b got %b", e.int_saturated,
                         rsp_ch.payload.int_saturated);
                  failures++;
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic tsfi_pkg::req_type make_item(input logic [2:0] code,
                                                   input logic [63:0] bits);
      tsfi_pkg::req_type it;
      it.type_code = code;
      it.raw_bits = bits;
      return it;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] b;
      b = rand64();
      case ($urandom_range(5))
         0: b[62:52] = 11'(1023 + $urandom_range(40));
         1: b[62:52] = 11'(1023 - 127 - $urandom_range(30));
         2: b[62:52] = 11'(1023 + 127 + $urandom_range(3));
         3: b[62:52] = 11'(1023 + 31);
         default: ;
      endcase
      if ($urandom_range(7) == 0) b[28:0] = $urandom_range(1) ? 29'h10000000 : 29'd0;
      return b;
   endfunction

   function automatic logic [63:0] random_single();
      logic [63:0] b;
      b = rand64();
      case ($urandom_range(4))
         0: b[30:23] = 8'(127 + $urandom_range(33));
         1: b[30:23] = 8'(127 + 31);
         2: b[30:23] = $urandom_range(1) ? 8'd0 : 8'hFF;
         default: ;
      endcase
      return b;
   endfunction

   initial begin
      logic [2:0] code;
      logic [63:0] b;
      pending_items.push_back(make_item(tsfi_pkg::TC_F32, 64'hFFFFFFFF_7FC00001));
      pending_items.push_back(make_item(tsfi_pkg::TC_F32, 64'h0000_0000_4F000000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F32, 64'h0000_0000_CF000000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F32, 64'h0000_0000_CF000001));
      pending_items.push_back(make_item(tsfi_pkg::TC_F32, 64'h0000_0000_BF7FFFFF));
      pending_items.push_back(make_item(tsfi_pkg::TC_F32, 64'h0000_0000_FF800000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'h7FF8_0000_E000_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'hFFF0_0000_0000_0001));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'h47EF_FFFF_F000_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'h36A0_0000_0000_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'h0000_0000_0000_0001));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'h41DF_FFFF_FFE0_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'hC1E0_0000_0020_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_F64, 64'hC1E0_0000_0000_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_S8, 64'hFFFF_FFFF_FFFF_FF80));
      pending_items.push_back(make_item(tsfi_pkg::TC_U8, 64'hFFFF_FFFF_FFFF_FFFF));
      pending_items.push_back(make_item(tsfi_pkg::TC_S16, 64'h0000_0000_0000_8000));
      pending_items.push_back(make_item(tsfi_pkg::TC_U16, 64'hFFFF_FFFF_FFFF_FFFF));
      pending_items.push_back(make_item(tsfi_pkg::TC_S32, 64'h0000_0000_8000_0000));
      pending_items.push_back(make_item(tsfi_pkg::TC_S32, 64'h0000_0000_7FFF_FFFF));
      pending_items.push_back(make_item(tsfi_pkg::TC_U32, 64'hFFFF_FFFF_FFFF_FFFF));
      pending_items.push_back(make_item(tsfi_pkg::TC_U32, 64'h0000_0000_0100_0001));
      pending_items.push_back(make_item(tsfi_pkg::TC_U32, 64'h0000_0000_0000_0000));
      for (int n = 0; n < N_RANDOM; n++) begin
         code = 3'($urandom_range(7));
         case (code)
            tsfi_pkg::TC_F32: b = random_single();
            tsfi_pkg::TC_F64: b = random_double();
            default: begin
               b = rand64();
               if ($urandom_range(3) == 0) b = b >> $urandom_range(63);
            end
         endcase
         pending_items.push_back(make_item(code, b));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() < N_RANDOM * 2 / 3);
      @(negedge clock);
      hold_send = 1'b1;
      wait (expected_rsps.size() == 0 && !req_ch.valid);
      @(negedge clock);
      send_idle_pct = 70;
      recv_idle_pct = 37;
      hold_send = 1'b0;
      wait (pending_items.size() < N_RANDOM / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_items.size() == 0 && !req_ch.valid);
      wait (expected_rsps.size() == 0);
      repeat (10) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
hdl/tsfi_pkg.sv
hdl/tsfi_stream_if.sv
hdl/tsfi_core.sv
hdl/typed_scalar_to_float_and_int.sv
sim/tb_typed_scalar_to_float_and_int.sv
